FILE: hdl/sstb_pkg.sv
// Shared types and constants of the scaled sprite tile blitter.
package sstb_pkg;

  localparam int LOC_W       = 10;
  localparam int GRID_W      = 8;
  localparam int GRID_N      = 1 << GRID_W;
  localparam int POS_W       = 12;
  localparam int DRAW_W      = 11;
  localparam int SADDR_W     = 16;
  localparam int PIX_W       = 32;
  localparam int SURF_ADDR_W = 20;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 12;

  localparam logic [PIX_W-1:0] ALPHA_MASK  = 32'h0000_00ff;
  localparam logic [PIX_W-1:0] ALPHA_LIMIT = 32'd1;

  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_RENDER = 1'b1
  } req_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_ROWS   = 3'd0,
    CFG_GRID_COLS   = 3'd1,
    CFG_DEST_LEFT   = 3'd2,
    CFG_DEST_TOP    = 3'd3,
    CFG_DRAW_WIDTH  = 3'd4,
    CFG_DRAW_HEIGHT = 3'd5,
    CFG_TILE_ROW    = 3'd6,
    CFG_TILE_COL    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    req_kind_t          req_type;
    logic [SADDR_W-1:0] load_addr;
    logic [PIX_W-1:0]   load_pixel;
    logic [LOC_W-1:0]   local_x;
    logic [LOC_W-1:0]   local_y;
  } req_t;

  typedef struct packed {
    logic                   write_enable;
    logic [SURF_ADDR_W-1:0] surface_addr;
    logic [PIX_W-1:0]       pixel_out;
  } rsp_t;

  // Per-request fields carried alongside the divider pipeline.
  typedef struct packed {
    logic                   is_load;
    logic                   go;
    logic [SURF_ADDR_W-1:0] surf_addr;
    logic [SADDR_W-1:0]     load_addr;
    logic [PIX_W-1:0]       load_pixel;
  } side_t;

  typedef struct packed {
    logic               en;
    logic               we;
    logic [SADDR_W-1:0] addr;
    logic [PIX_W-1:0]   wdata;
  } mem_req_t;

endpackage

FILE: hdl/sstb_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module sstb_div #(
  parameter int NUM_W = 19,
  parameter int DEN_W = 11,
  parameter int QUO_W = 9
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  localparam int CW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic [NUM_W-1:0] rem_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int Sh = QUO_W - 1 - k;
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic [CW-1:0]    trial;
    logic             fits;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign trial = CW'(den_in) << Sh;
    assign fits  = CW'(rem_in) >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= fits ? NUM_W'(CW'(rem_in) - trial) : rem_in;
        den_q[k] <= den_in;
        quo_q[k] <= fits ? (quo_in | (QUO_W'(1) << Sh)) : quo_in;
      end
    end
  end

  assign quo = quo_q[QUO_W-1];

endmodule

FILE: hdl/sstb_sheet_mem.sv
// Sprite sheet pixel store: single port, registered read.
module sstb_sheet_mem (
  input  logic                           clk,
  input  sstb_pkg::mem_req_t             req,
  output logic [sstb_pkg::PIX_W-1:0]     rdata
);

  localparam int Depth = 1 << sstb_pkg::SADDR_W;

  logic [sstb_pkg::PIX_W-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rdata <= mem[req.addr];
      end
    end
  end

endmodule

FILE: hdl/scaled_sprite_tile_blit.sv
// Nearest-neighbor scaled sprite tile blitter: top level.
//
// Requests enter on req_valid/req_stall. A load request writes one pixel of
// the sprite sheet; a render request maps a sprite-local coordinate to a
// sheet pixel and yields one surface write (or an all-zero result when the
// pixel is outside the sprite, clipped, or transparent). Every request gives
// exactly one result on rsp_valid/rsp_stall, in request order.
// Configuration registers are written on cfg_valid/cfg_ready (always ready);
// write them only while no request is in flight (the block does not enforce it).
// A result passes the request register, stage A, the divider stages, stages
// C, D and M and the output register; QW = clog2(max(SHEET_WIDTH,SHEET_HEIGHT)+1)
// is the depth of the per-pixel divider pipelines.
// Throughput: one request per clock; sheet reads and writes share the one
// memory port at a single pipeline stage, so a render sees all earlier loads.
// When the receiver stalls, a skid register takes one more result; once it is
// full, req_stall rises and the whole pipeline holds.
// Reset clears the pipeline and sets the registers to their defaults; the
// sheet store is not cleared and holds nothing meaningful until loaded.
module scaled_sprite_tile_blit #(
  parameter int SURFACE_WIDTH  = 1024,
  parameter int SURFACE_HEIGHT = 1024,
  parameter int SHEET_WIDTH    = 256,
  parameter int SHEET_HEIGHT   = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  sstb_pkg::req_t                      req_data,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output sstb_pkg::rsp_t                      rsp_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sstb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sstb_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int GW   = sstb_pkg::GRID_W;
  localparam int LW   = sstb_pkg::LOC_W;
  localparam int DW   = sstb_pkg::DRAW_W;
  localparam int PW   = sstb_pkg::POS_W;
  localparam int SAW  = sstb_pkg::SADDR_W;
  localparam int SFW  = sstb_pkg::SURF_ADDR_W;
  localparam int TWW  = $clog2(SHEET_WIDTH + 1);
  localparam int THW  = $clog2(SHEET_HEIGHT + 1);
  localparam int QW   = (TWW > THW) ? TWW : THW;
  localparam int NXW  = LW + TWW;
  localparam int NYW  = LW + THW;
  localparam int X0W  = GW + TWW;
  localparam int Y0W  = GW + THW;
  localparam int SXF  = X0W + 1;
  localparam int SYF  = Y0W + 1;
  localparam int SXW  = $clog2(SHEET_WIDTH);
  localparam int SYW  = $clog2(SHEET_HEIGHT);

  // Configuration registers
  logic [GW-1:0]        grid_rows;
  logic [GW-1:0]        grid_cols;
  logic signed [PW-1:0] dest_left;
  logic signed [PW-1:0] dest_top;
  logic [DW-1:0]        draw_width;
  logic [DW-1:0]        draw_height;
  logic [GW-1:0]        tile_row;
  logic [GW-1:0]        tile_col;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows   <= GW'(1);
      grid_cols   <= GW'(1);
      dest_left   <= '0;
      dest_top    <= '0;
      draw_width  <= DW'(1);
      draw_height <= DW'(1);
      tile_row    <= '0;
      tile_col    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (sstb_pkg::cfg_reg_t'(cfg_index))
        sstb_pkg::CFG_GRID_ROWS:   grid_rows   <= cfg_data[GW-1:0];
        sstb_pkg::CFG_GRID_COLS:   grid_cols   <= cfg_data[GW-1:0];
        sstb_pkg::CFG_DEST_LEFT:   dest_left   <= cfg_data[PW-1:0];
        sstb_pkg::CFG_DEST_TOP:    dest_top    <= cfg_data[PW-1:0];
        sstb_pkg::CFG_DRAW_WIDTH:  draw_width  <= cfg_data[DW-1:0];
        sstb_pkg::CFG_DRAW_HEIGHT: draw_height <= cfg_data[DW-1:0];
        sstb_pkg::CFG_TILE_ROW:    tile_row    <= cfg_data[GW-1:0];
        sstb_pkg::CFG_TILE_COL:    tile_col    <= cfg_data[GW-1:0];
        default: ;
      endcase
    end
  end

  // Tile size tables, sheet size over grid count; a zero grid counts as one.
  logic [TWW-1:0] tw_tab [sstb_pkg::GRID_N];
  logic [THW-1:0] th_tab [sstb_pkg::GRID_N];

  for (genvar g = 0; g < sstb_pkg::GRID_N; g++) begin : g_tile_tab
    localparam int Tw = SHEET_WIDTH / ((g == 0) ? 1 : g);
    localparam int Th = SHEET_HEIGHT / ((g == 0) ? 1 : g);
    assign tw_tab[g] = TWW'(Tw);
    assign th_tab[g] = THW'(Th);
  end

  // Values derived from configuration, registered: tile size, then tile origin
  logic [TWW-1:0] tile_w;
  logic [THW-1:0] tile_h;
  logic [X0W-1:0] tile_x0;
  logic [Y0W-1:0] tile_y0;

  always_ff @(posedge clk) begin
    tile_w  <= tw_tab[grid_cols];
    tile_h  <= th_tab[grid_rows];
    tile_x0 <= X0W'(tile_col) * X0W'(tile_w);
    tile_y0 <= Y0W'(tile_row) * Y0W'(tile_h);
  end

  // Pipeline control
  logic adv;
  logic sk_valid;

  assign adv       = !sk_valid;
  assign req_stall = sk_valid;

  logic          s0_valid;
  logic          a_valid;
  logic [QW-1:0] dv;
  logic          c_valid;
  logic          d_valid;
  logic          m_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      a_valid  <= 1'b0;
      dv       <= '0;
      c_valid  <= 1'b0;
      d_valid  <= 1'b0;
      m_valid  <= 1'b0;
    end else if (adv) begin
      s0_valid <= req_valid;
      a_valid  <= s0_valid;
      dv       <= {dv[QW-2:0], a_valid};
      c_valid  <= dv[QW-1];
      d_valid  <= c_valid;
      m_valid  <= d_valid;
    end
  end

  // Stage 0: request register
  sstb_pkg::req_t s0_req;

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_req <= req_data;
    end
  end

  // Stage A: sprite and surface clip, surface address, divider numerators
  logic [PW:0]      dx;
  logic [PW:0]      dy;
  logic             in_sprite;
  logic             on_surface;
  sstb_pkg::side_t  a_side_next;
  sstb_pkg::side_t  a_side;
  logic [NXW-1:0]   num_x;
  logic [NYW-1:0]   num_y;

  assign dx = {dest_left[PW-1], dest_left} + (PW+1)'(s0_req.local_x);
  assign dy = {dest_top[PW-1], dest_top} + (PW+1)'(s0_req.local_y);

  assign in_sprite  = (DW'(s0_req.local_x) < draw_width) &&
                      (DW'(s0_req.local_y) < draw_height);
  assign on_surface = !dx[PW] && (dx[PW-1:0] < PW'(SURFACE_WIDTH)) &&
                      !dy[PW] && (dy[PW-1:0] < PW'(SURFACE_HEIGHT));

  always_comb begin
    a_side_next.is_load    = (s0_req.req_type == sstb_pkg::REQ_LOAD);
    a_side_next.go         = (s0_req.req_type == sstb_pkg::REQ_RENDER) &&
                             in_sprite && on_surface;
    a_side_next.surf_addr  = SFW'(dx[PW-1:0] + dy[PW-1:0] * SURFACE_WIDTH);
    a_side_next.load_addr  = s0_req.load_addr;
    a_side_next.load_pixel = s0_req.load_pixel;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_side <= a_side_next;
      num_x  <= NXW'(s0_req.local_x) * NXW'(tile_w);
      num_y  <= NYW'(s0_req.local_y) * NYW'(tile_h);
    end
  end

  // Divider stages: floor(local * tile / draw)
  logic [QW-1:0]   quo_x;
  logic [QW-1:0]   quo_y;
  sstb_pkg::side_t side_d [QW];

  sstb_div #(.NUM_W(NXW), .DEN_W(DW), .QUO_W(QW)) u_div_x (
    .clk (clk),
    .en  (adv),
    .num (num_x),
    .den (draw_width),
    .quo (quo_x)
  );

  sstb_div #(.NUM_W(NYW), .DEN_W(DW), .QUO_W(QW)) u_div_y (
    .clk (clk),
    .en  (adv),
    .num (num_y),
    .den (draw_height),
    .quo (quo_y)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      side_d[0] <= a_side;
      for (int k = 1; k < QW; k++) begin
        side_d[k] <= side_d[k-1];
      end
    end
  end

  // Stage C: source coordinate and sheet clip
  logic [SXF-1:0]  sx_full;
  logic [SYF-1:0]  sy_full;
  sstb_pkg::side_t c_side_next;
  sstb_pkg::side_t c_side;
  logic [SXW-1:0]  c_sx;
  logic [SYW-1:0]  c_sy;

  assign sx_full = SXF'(tile_x0) + SXF'(quo_x);
  assign sy_full = SYF'(tile_y0) + SYF'(quo_y);

  always_comb begin
    c_side_next    = side_d[QW-1];
    c_side_next.go = side_d[QW-1].go && (sx_full < SXF'(SHEET_WIDTH)) &&
                     (sy_full < SYF'(SHEET_HEIGHT));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_side <= c_side_next;
      c_sx   <= SXW'(sx_full);
      c_sy   <= SYW'(sy_full);
    end
  end

  // Stage D: sheet address
  sstb_pkg::side_t d_side;
  logic [SAW-1:0]  d_addr;
  logic [SAW-1:0]  sheet_addr;

  assign sheet_addr = SAW'(c_sx + c_sy * SHEET_WIDTH);

  always_ff @(posedge clk) begin
    if (adv) begin
      d_side <= c_side;
      d_addr <= c_side.is_load ? c_side.load_addr : sheet_addr;
    end
  end

  // Stage M: the one access to the sheet. Loads and renders hit the store at
  // this same stage in request order, so no forwarding is needed.
  sstb_pkg::mem_req_t              mem_req;
  logic [sstb_pkg::PIX_W-1:0]      mem_rdata;
  sstb_pkg::side_t                 m_side;

  always_comb begin
    mem_req.en    = adv && d_valid;
    mem_req.we    = d_side.is_load;
    mem_req.addr  = d_addr;
    mem_req.wdata = d_side.load_pixel;
  end

  sstb_sheet_mem u_sheet (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      m_side <= d_side;
    end
  end

  // Transparency test and result formatting
  sstb_pkg::rsp_t res;
  logic           opaque;

  assign opaque = (mem_rdata & sstb_pkg::ALPHA_MASK) > sstb_pkg::ALPHA_LIMIT;

  always_comb begin
    res = '0;
    if (m_side.go && opaque) begin
      res.write_enable = 1'b1;
      res.surface_addr = m_side.surf_addr;
      res.pixel_out    = mem_rdata;
    end
  end

  // Output register plus skid register
  sstb_pkg::rsp_t sk_data;
  logic           take;

  assign take = rsp_valid && !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      sk_valid  <= 1'b0;
    end else if (sk_valid) begin
      if (take) begin
        rsp_data <= sk_data;
        sk_valid <= 1'b0;
      end
    end else if (m_valid) begin
      if (!rsp_valid || take) begin
        rsp_valid <= 1'b1;
        rsp_data  <= res;
      end else begin
        sk_valid <= 1'b1;
        sk_data  <= res;
      end
    end else if (take) begin
      rsp_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    sk_valid |-> (rsp_valid && req_stall))
    else $error("skid holds a result while output register is empty");

  a_no_write_is_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_data.write_enable) |->
      (rsp_data.surface_addr == '0 && rsp_data.pixel_out == '0))
    else $error("result without write carries nonzero fields");

  a_hold_when_full: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(m_valid) && $stable(mem_rdata) && $stable(m_side)))
    else $error("memory stage changed while pipeline held");
`endif

endmodule

FILE: bench/sstb_blit_checker.sv
// Result checker for the scaled sprite tile blitter: mirrors the sheet, predicts, compares.
module sstb_blit_checker #(
  parameter int SURFACE_WIDTH  = 1024,
  parameter int SURFACE_HEIGHT = 1024,
  parameter int SHEET_WIDTH    = 256,
  parameter int SHEET_HEIGHT   = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  input  logic                            req_stall,
  input  sstb_pkg::req_t                  req_data,
  input  logic                            rsp_valid,
  input  logic                            rsp_stall,
  input  sstb_pkg::rsp_t                  rsp_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [sstb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sstb_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              errors,
  output int                              pending
);
  import sstb_pkg::*;

  logic [PIX_W-1:0] sheet_copy [0:(1 << SADDR_W)-1];
  rsp_t             writes_due [$];
  rsp_t             due;

  int rows_n, cols_n, left_n, top_n, dw_n, dh_n, trow_n, tcol_n;

  // Expected surface write for one render request.
  function automatic rsp_t map_render_pixel(req_t r);
    int lx, ly, dx, dy, rws, cls, tw, th, sx, sy;
    logic [PIX_W-1:0] pix;
    rsp_t res;
    res = '0;
    lx = r.local_x;
    ly = r.local_y;
    if (lx >= dw_n || ly >= dh_n) return res;
    dx = left_n + lx;
    dy = top_n + ly;
    if (dx < 0 || dx >= SURFACE_WIDTH || dy < 0 || dy >= SURFACE_HEIGHT) return res;
    rws = (rows_n == 0) ? 1 : rows_n;
    cls = (cols_n == 0) ? 1 : cols_n;
    tw = SHEET_WIDTH / cls;
    th = SHEET_HEIGHT / rws;
    sx = tcol_n * tw + (lx * tw) / dw_n;
    sy = trow_n * th + (ly * th) / dh_n;
    if (sx >= SHEET_WIDTH || sy >= SHEET_HEIGHT) return res;
    pix = sheet_copy[SADDR_W'(sx + sy * SHEET_WIDTH)];
    if ((pix & ALPHA_MASK) <= ALPHA_LIMIT) return res;
    res.write_enable = 1'b1;
    res.surface_addr = SURF_ADDR_W'(dx + dy * SURFACE_WIDTH);
    res.pixel_out    = pix;
    return res;
  endfunction

  task automatic note_mismatch(string what, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rows_n = 1;
      cols_n = 1;
      left_n = 0;
      top_n  = 0;
      dw_n   = 1;
      dh_n   = 1;
      trow_n = 0;
      tcol_n = 0;
      writes_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_GRID_ROWS:   rows_n = cfg_data[GRID_W-1:0];
          CFG_GRID_COLS:   cols_n = cfg_data[GRID_W-1:0];
          CFG_DEST_LEFT:   left_n = $signed(cfg_data);
          CFG_DEST_TOP:    top_n  = $signed(cfg_data);
          CFG_DRAW_WIDTH:  dw_n   = cfg_data[DRAW_W-1:0];
          CFG_DRAW_HEIGHT: dh_n   = cfg_data[DRAW_W-1:0];
          CFG_TILE_ROW:    trow_n = cfg_data[GRID_W-1:0];
          CFG_TILE_COL:    tcol_n = cfg_data[GRID_W-1:0];
          default: ;
        endcase
      end
      // requests before results: the store must see loads in arrival order
      if (req_valid && !req_stall) begin
        if (req_data.req_type == REQ_LOAD) begin
          sheet_copy[req_data.load_addr] = req_data.load_pixel;
          writes_due.push_back('0);
        end else begin
          writes_due.push_back(map_render_pixel(req_data));
        end
      end
      if (rsp_valid && !rsp_stall) begin
        if (writes_due.size() == 0) begin
          errors++;
          $display("%0t: result with none expected, expected nothing, got %h",
                   $time, rsp_data);
        end else begin
          due = writes_due.pop_front();
          if (rsp_data.write_enable !== due.write_enable)
            note_mismatch("write_enable", due.write_enable, rsp_data.write_enable);
          if (rsp_data.surface_addr !== due.surface_addr)
            note_mismatch("surface_addr", due.surface_addr, rsp_data.surface_addr);
          if (rsp_data.pixel_out !== due.pixel_out)
            note_mismatch("pixel_out", due.pixel_out, rsp_data.pixel_out);
        end
      end
    end
    pending = writes_due.size();
  end

endmodule

FILE: bench/tb.sv
// Testbench top for the scaled sprite tile blitter: stimulus, pacing and verdict.
module tb;
  import sstb_pkg::*;

  localparam int SURF_W      = 1024;
  localparam int SURF_H      = 1024;
  localparam int SHEET_W     = 256;
  localparam int SHEET_H     = 256;
  localparam int SETTLE      = 32;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 90;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  req_t                  req_data  = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  rsp_t                  rsp_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int  errors;
  int  pending;
  int  cycles    = 0;
  int  rsp_hold  = 0;
  bit  quiet     = 1'b0;
  bit  loaded [0:(1 << SADDR_W)-1];
  logic [CFG_DATA_W-1:0] setup [8];

  always #10 clk = ~clk;

  scaled_sprite_tile_blit #(
    .SURFACE_WIDTH (SURF_W),
    .SURFACE_HEIGHT(SURF_H),
    .SHEET_WIDTH   (SHEET_W),
    .SHEET_HEIGHT  (SHEET_H)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data (rsp_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  sstb_blit_checker #(
    .SURFACE_WIDTH (SURF_W),
    .SURFACE_HEIGHT(SURF_H),
    .SHEET_WIDTH   (SHEET_W),
    .SHEET_HEIGHT  (SHEET_H)
  ) u_chk (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data (rsp_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .errors   (errors),
    .pending  (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[scaled_sprite_tile_blit] ERROR");
      $finish;
    end
  end

  // Receiver: after each taken result, hold off the next one for a drawn count.
  always @(posedge clk) begin : rsp_pacing
    int hold_draw;
    if (rsp_hold > 0) begin
      rsp_hold <= rsp_hold - 1;
      if (rsp_hold == 1) rsp_stall <= 1'b0;
    end else if (!rst && rsp_valid && !rsp_stall) begin
      hold_draw = quiet ? 0 : $urandom_range(0, 15);
      if (hold_draw > 0) begin
        rsp_hold  <= hold_draw;
        rsp_stall <= 1'b1;
      end
    end
  end

  function automatic req_t scrambled_request();
    logic [95:0] bits;
    req_t r;
    bits = {$urandom, $urandom, $urandom};
    r = bits[$bits(req_t)-1:0];
    return r;
  endfunction

  // About a sixth of sheet pixels are transparent.
  function automatic logic [PIX_W-1:0] sheet_value();
    logic [PIX_W-1:0] v;
    v = $urandom;
    if ($urandom_range(0, 3) == 0) v[7:0] = 8'($urandom_range(0, 2));
    return v;
  endfunction

  function automatic int pick_grid();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(1, 4);
      1:       return 1 << $urandom_range(0, 7);
      2:       return $urandom_range(1, 255);
      default: return ($urandom_range(0, 1) == 0) ? 1 : 255;
    endcase
  endfunction

  task automatic issue_request(req_t r);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic store_sheet_pixel(int addr, logic [PIX_W-1:0] pix);
    req_t r;
    r = scrambled_request();
    r.req_type   = REQ_LOAD;
    r.load_addr  = addr[SADDR_W-1:0];
    r.load_pixel = pix;
    loaded[addr[SADDR_W-1:0]] = 1'b1;
    issue_request(r);
  endtask

  // Loads the source pixel first if it was never written, so no render reads junk.
  task automatic draw_pixel(int lx, int ly);
    int rws, cls, dw, dh, trow, tcol, sx, sy;
    req_t r;
    rws  = setup[CFG_GRID_ROWS][GRID_W-1:0];
    cls  = setup[CFG_GRID_COLS][GRID_W-1:0];
    dw   = setup[CFG_DRAW_WIDTH][DRAW_W-1:0];
    dh   = setup[CFG_DRAW_HEIGHT][DRAW_W-1:0];
    trow = setup[CFG_TILE_ROW][GRID_W-1:0];
    tcol = setup[CFG_TILE_COL][GRID_W-1:0];
    if (rws == 0) rws = 1;
    if (cls == 0) cls = 1;
    if (dw != 0 && dh != 0) begin
      sx = tcol * (SHEET_W / cls) + (lx * (SHEET_W / cls)) / dw;
      sy = trow * (SHEET_H / rws) + (ly * (SHEET_H / rws)) / dh;
      if (sx < SHEET_W && sy < SHEET_H && !loaded[sx + sy * SHEET_W])
        store_sheet_pixel(sx + sy * SHEET_W, sheet_value());
    end
    r = scrambled_request();
    r.req_type = REQ_RENDER;
    r.local_x  = lx[LOC_W-1:0];
    r.local_y  = ly[LOC_W-1:0];
    issue_request(r);
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t ix, int v);
    setup[ix]  = v[CFG_DATA_W-1:0];
    cfg_valid <= 1'b1;
    cfg_index <= ix;
    cfg_data  <= v[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_sprite(int rows, int cols, int left, int top,
                            int dw, int dh, int trow, int tcol);
    settle();
    write_reg(CFG_GRID_ROWS, rows);
    write_reg(CFG_GRID_COLS, cols);
    write_reg(CFG_DEST_LEFT, left);
    write_reg(CFG_DEST_TOP, top);
    write_reg(CFG_DRAW_WIDTH, dw);
    write_reg(CFG_DRAW_HEIGHT, dh);
    write_reg(CFG_TILE_ROW, trow);
    write_reg(CFG_TILE_COL, tcol);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int rows, cols, dw, dh, pick, span_w, span_h;
    setup[CFG_GRID_ROWS]   = CFG_DATA_W'(1);
    setup[CFG_GRID_COLS]   = CFG_DATA_W'(1);
    setup[CFG_DEST_LEFT]   = '0;
    setup[CFG_DEST_TOP]    = '0;
    setup[CFG_DRAW_WIDTH]  = CFG_DATA_W'(1);
    setup[CFG_DRAW_HEIGHT] = CFG_DATA_W'(1);
    setup[CFG_TILE_ROW]    = '0;
    setup[CFG_TILE_COL]    = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings: 1x1 sprite from the whole sheet
    store_sheet_pixel(0, 32'hffff_ff02);
    store_sheet_pixel(16'hffff, 32'h0000_0000);
    store_sheet_pixel(16'hffff, 32'hffff_ffff);
    draw_pixel(0, 0);
    draw_pixel(1, 0);
    draw_pixel(1023, 1023);
    store_sheet_pixel(0, 32'hffff_ff01);
    draw_pixel(0, 0);
    store_sheet_pixel(0, 32'h8000_0000);
    draw_pixel(0, 0);
    // zero grid counts as one; far corner of sheet and surface
    set_sprite(0, 0, 0, 0, 1024, 1024, 0, 0);
    draw_pixel(1023, 1023);
    draw_pixel(512, 0);
    // surface clip at the position extremes
    set_sprite(255, 255, -2048, 2047, 1, 1, 255, 255);
    draw_pixel(0, 0);
    // zero draw size never writes
    set_sprite(255, 255, 1023, 1023, 0, 0, 255, 255);
    draw_pixel(0, 0);
    set_sprite(255, 255, 1023, 1023, 2047, 2047, 255, 255);
    draw_pixel(0, 0);
    draw_pixel(1, 0);
    // tile past the sheet edge
    set_sprite(4, 4, -1, -1, 16, 16, 3, 4);
    draw_pixel(5, 5);
    draw_pixel(0, 0);
    set_sprite(2, 2, 0, 0, 1024, 8, 1, 1);
    draw_pixel(1023, 7);
    draw_pixel(0, 0);

    for (int ph = 0; ph < PHASES; ph++) begin
      rows = pick_grid();
      cols = pick_grid();
      dw = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 1024);
      dh = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 1024);
      set_sprite(rows, cols,
                 ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 4095)) - 2048
                                             : int'($urandom_range(0, 1100)) - 80,
                 ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 4095)) - 2048
                                             : int'($urandom_range(0, 1100)) - 80,
                 dw, dh,
                 ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                             : $urandom_range(0, rows - 1),
                 ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                             : $urandom_range(0, cols - 1));
      quiet  = ($urandom_range(0, 3) == 0);
      span_w = (dw > 1024) ? 1024 : dw;
      span_h = (dh > 1024) ? 1024 : dh;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 9);
        if (pick < 3)
          store_sheet_pixel($urandom_range(0, (1 << SADDR_W) - 1), sheet_value());
        else if (pick < 9)
          draw_pixel($urandom_range(0, span_w - 1), $urandom_range(0, span_h - 1));
        else
          draw_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
      end
    end

    quiet = 1'b0;
    settle();
    if (errors == 0 && pending == 0)
      $display("[scaled_sprite_tile_blit] OK");
    else
      $display("[scaled_sprite_tile_blit] ERROR");
    $finish;
  end

endmodule
